FILE: hdl/tbtl_pkg.sv
// shared types and constants for the touch button tap latch
`default_nettype none
package tbtl_pkg;

  localparam int MAX_FINGERS = 15;
  localparam int COUNT_W     = $clog2(MAX_FINGERS + 1);
  localparam int TIME_BITS   = 32;
  localparam int LIMIT_W     = 16;

  localparam logic [LIMIT_W-1:0] TAP_MAX_RESET = 16'd250;
  localparam logic [LIMIT_W-1:0] GAP_MAX_RESET = 16'd320;

  typedef enum logic [2:0] {
    OP_BEGIN      = 3'd0,
    OP_END        = 3'd1,
    OP_CANCEL     = 3'd2,
    OP_ROLL_BEGIN = 3'd3,
    OP_ROLL_END   = 3'd4
  } op_t;

  typedef enum logic [0:0] {
    REG_TAP_MAX = 1'b0,
    REG_GAP_MAX = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] tap_max;
    logic [LIMIT_W-1:0] gap_max;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic latched;
    logic toggled;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/tbtl_engine.sv
// finger counting, tap detection and latch state update
`default_nettype none
module tbtl_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  wire  [2:0]                        op,
  input  wire  [tbtl_pkg::TIME_BITS-1:0]    now,
  input  wire                               allow,
  input  wire  tbtl_pkg::cfg_t              cfg,
  output tbtl_pkg::result_t                 res
);
  import tbtl_pkg::*;

  logic [COUNT_W-1:0]   finger_count_r, finger_count_nxt;
  logic [COUNT_W-1:0]   rolled_count_r, rolled_count_nxt;
  logic [TIME_BITS-1:0] touch_start_r, touch_start_nxt;
  logic                 single_r, single_nxt;
  logic [TIME_BITS-1:0] last_tap_time_r, last_tap_time_nxt;
  logic                 last_tap_valid_r, last_tap_valid_nxt;
  logic                 latch_on_r, latch_on_nxt;

  function automatic logic span_within(input logic [TIME_BITS-1:0] earlier,
                                       input logic [TIME_BITS-1:0] later,
                                       input logic [LIMIT_W-1:0]   limit);
    logic [TIME_BITS-1:0] diff;
    diff = later - earlier;
    return (later >= earlier) && (diff <= TIME_BITS'(limit));
  endfunction

  logic [COUNT_W-1:0] finger_dec;
  logic               tap;
  logic               flipped;

  always_comb begin
    finger_count_nxt   = finger_count_r;
    rolled_count_nxt   = rolled_count_r;
    touch_start_nxt    = touch_start_r;
    single_nxt         = single_r;
    last_tap_time_nxt  = last_tap_time_r;
    last_tap_valid_nxt = last_tap_valid_r;
    latch_on_nxt       = latch_on_r;
    finger_dec         = finger_count_r - COUNT_W'(1);
    tap                = allow && single_r && span_within(touch_start_r, now, cfg.tap_max);
    flipped            = 1'b0;
    case (op_t'(op))
      OP_BEGIN: begin
        if (finger_count_r == '0) begin
          touch_start_nxt = now;
          single_nxt      = 1'b1;
        end else begin
          single_nxt = 1'b0;
        end
        if (finger_count_r < COUNT_W'(MAX_FINGERS)) begin
          finger_count_nxt = finger_count_r + COUNT_W'(1);
        end
      end
      OP_END: begin
        if (finger_count_r != '0) begin
          finger_count_nxt = finger_dec;
          if (finger_dec == '0) begin
            // second tap of a double tap flips the latch
            if (tap && last_tap_valid_r &&
                span_within(last_tap_time_r, touch_start_r, cfg.gap_max)) begin
              latch_on_nxt       = !latch_on_r;
              last_tap_valid_nxt = 1'b0;
              flipped            = 1'b1;
            end else begin
              last_tap_valid_nxt = tap;
              last_tap_time_nxt  = now;
            end
          end
        end
      end
      OP_CANCEL: begin
        finger_count_nxt   = '0;
        rolled_count_nxt   = '0;
        touch_start_nxt    = '0;
        single_nxt         = 1'b0;
        last_tap_time_nxt  = '0;
        last_tap_valid_nxt = 1'b0;
        latch_on_nxt       = 1'b0;
      end
      OP_ROLL_BEGIN: begin
        if (rolled_count_r < COUNT_W'(MAX_FINGERS)) begin
          rolled_count_nxt = rolled_count_r + COUNT_W'(1);
        end
      end
      OP_ROLL_END: begin
        if (rolled_count_r != '0) begin
          rolled_count_nxt = rolled_count_r - COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.pressed = (finger_count_nxt != '0) || (rolled_count_nxt != '0) || latch_on_nxt;
    res.latched = latch_on_nxt;
    res.toggled = flipped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_count_r   <= '0;
      rolled_count_r   <= '0;
      touch_start_r    <= '0;
      single_r         <= 1'b0;
      last_tap_time_r  <= '0;
      last_tap_valid_r <= 1'b0;
      latch_on_r       <= 1'b0;
    end else if (en) begin
      finger_count_r   <= finger_count_nxt;
      rolled_count_r   <= rolled_count_nxt;
      touch_start_r    <= touch_start_nxt;
      single_r         <= single_nxt;
      last_tap_time_r  <= last_tap_time_nxt;
      last_tap_valid_r <= last_tap_valid_nxt;
      latch_on_r       <= latch_on_nxt;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (finger_count_r <= COUNT_W'(MAX_FINGERS)) && (rolled_count_r <= COUNT_W'(MAX_FINGERS)))
    else $error("finger count above limit");

  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.toggled) |=> (latch_on_r != $past(latch_on_r)) && !last_tap_valid_r)
    else $error("toggle did not flip latch or consume previous tap");

  a_cancel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (op == OP_CANCEL)) |=>
      (finger_count_r == '0) && (rolled_count_r == '0) && !latch_on_r && !last_tap_valid_r)
    else $error("cancel left state behind");

  a_single_needs_finger: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (op == OP_BEGIN) && (finger_count_r != '0)) |=> !single_r)
    else $error("chord still marked single finger");

endmodule
`default_nettype wire

FILE: hdl/touch_button_tap_latch_core.sv
// touch button tap latch: input register, event engine and result register
// path: event held in input register, then result register (out_valid) when the slot is free
// throughput: one event per cycle while out_ready is high; the input and result registers
//   pipeline, so a new event is taken while the previous result waits
// reset: rst_n synchronous active low; clears all touch state, empties both stages
//   and restores tap_max_ms = 250 and gap_max_ms = 320
`default_nettype none
module touch_button_tap_latch_core (
  input  wire         clk,
  input  wire         rst_n,
  // event input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_operation,
  input  wire  [31:0] in_timestamp_ms,
  input  wire         in_can_latch,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_pressed,
  output logic        out_latched,
  output logic        out_toggled,
  // configuration writes
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);
  import tbtl_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_max <= TAP_MAX_RESET;
      cfg_r.gap_max <= GAP_MAX_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TAP_MAX: cfg_r.tap_max <= cfg_wdata;
        REG_GAP_MAX: cfg_r.gap_max <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input stage: holds one accepted event
  logic                 in_v_r;
  logic [2:0]           op_r;
  logic [TIME_BITS-1:0] ts_r;
  logic                 allow_r;

  // result stage
  logic    out_v_r;
  result_t res_r;
  result_t res_nxt;

  // event moves from input stage into result stage when the result slot frees up
  logic advance;
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      ts_r    <= TIME_BITS'(in_timestamp_ms);
      allow_r <= in_can_latch;
    end
  end

  // state update happens exactly when the event leaves the input stage
  tbtl_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .op    (op_r),
    .now   (ts_r),
    .allow (allow_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_pressed = res_r.pressed;
  assign out_latched = res_r.latched;
  assign out_toggled = res_r.toggled;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |-> !advance)
    else $error("result overwritten before transfer");

  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("advanced event produced no result");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> in_v_r && $stable(op_r) && $stable(ts_r))
    else $error("stalled event lost from input stage");

endmodule
`default_nettype wire
